@@ rtl/qra_pkg.sv @@
// ----------------------------------------------------------------------------
// qra_pkg
// Shared widths, register map, reset values and control types of the
// quantized residual add / ReLU block.
// ----------------------------------------------------------------------------
package qra_pkg;

    localparam int ACC_W   = 32;
    localparam int MULT_W  = 31;
    localparam int SHIFT_W = 6;
    localparam int PROD_W  = 63;
    localparam int WIDE_W  = 64;
    localparam int OUT_W   = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [MULT_W-1:0]         MAIN_MULT_RST  = 31'd1219494715;
    localparam logic signed [SHIFT_W-1:0] MAIN_SHIFT_RST = -6'sd6;
    localparam logic [MULT_W-1:0]         SC_MULT_RST    = 31'd1193971754;
    localparam logic signed [SHIFT_W-1:0] SC_SHIFT_RST   = -6'sd5;

    localparam logic [OUT_W-1:0] OUT_MAX = 8'd255;

    // Register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_MAIN_MULT  = 2'd0,
        REG_MAIN_SHIFT = 2'd1,
        REG_SC_MULT    = 2'd2,
        REG_SC_SHIFT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [MULT_W-1:0]         main_mult;
        logic signed [SHIFT_W-1:0] main_shift;
        logic [MULT_W-1:0]         sc_mult;
        logic signed [SHIFT_W-1:0] sc_shift;
    } t_cfg;

    // Per-stage load strobes of the rescale datapath
    typedef struct packed {
        logic mul;
        logic lsh;
        logic rnd;
        logic rsh;
    } t_stage_en;

endpackage

@@ rtl/qra_if.sv @@
// ----------------------------------------------------------------------------
// qra_in_if / qra_out_if
// Valid/ready stream channels for accumulator pairs and merged activations.
// ----------------------------------------------------------------------------
interface qra_in_if;
    import qra_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  main_acc;
    logic signed [ACC_W-1:0]  shortcut_acc;
    logic                     last_in;

    modport source (output valid, output main_acc, output shortcut_acc, output last_in,
                    input ready);
    modport sink   (input valid, input main_acc, input shortcut_acc, input last_in,
                    output ready);
endinterface

interface qra_out_if;
    import qra_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] out_value;
    logic             last_out;

    modport source (output valid, output out_value, output last_out, input ready);
    modport sink   (input valid, input out_value, input last_out, output ready);
endinterface

@@ rtl/quantized_residual_add_relu.sv @@
// ----------------------------------------------------------------------------
// quantized_residual_add_relu
// Requantizes a main and a shortcut int32 accumulator, adds them, applies
// ReLU and clamps to uint8.
// ----------------------------------------------------------------------------
// Pipeline: multiply, left shift, round, right shift and add/clamp stages,
//   each stage a register, from input beat to output beat.
// Throughput: one beat per cycle while the sink is ready; each stage holds its own
//   valid bit, so a bubble is squeezed out and a new beat can enter while the output waits.
// Reset: synchronous active low; clears all valid bits and loads the
//   multiplier and shift registers with their default values.
// ----------------------------------------------------------------------------
module quantized_residual_add_relu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    qra_in_if.sink                      i_in,
    qra_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qra_pkg::ADDR_W-1:0]  paddr,
    input  logic [qra_pkg::DATA_W-1:0]  pwdata,
    output logic [qra_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import qra_pkg::*;

    localparam int NSTG = 5;

    t_cfg                    w_cfg;
    t_stage_en               w_en;
    logic [NSTG-1:0]         w_rdy;
    logic [NSTG-1:0]         w_ld;
    logic [NSTG-1:0]         w_up_vld;
    logic signed [ACC_W-1:0] w_main;
    logic signed [ACC_W-1:0] w_sc;
    logic signed [ACC_W:0]   w_sum;
    logic [OUT_W-1:0]        w_clamp;

    logic [NSTG-1:0]         r_vld;
    logic [NSTG-1:0]         r_last;
    logic [OUT_W-1:0]        r_value;

    // Register file
    qra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stage handshake: a stage takes a beat when it is empty or its own beat
    // moves on in the same cycle. The chain runs back from the output.
    assign w_up_vld = {r_vld[NSTG-2:0], i_in.valid};

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Load payload only when a real beat arrives; bubbles just clear valid
    assign w_ld = w_rdy & w_up_vld;

    assign w_en.mul = w_ld[0];
    assign w_en.lsh = w_ld[1];
    assign w_en.rnd = w_ld[2];
    assign w_en.rsh = w_ld[3];

    assign i_in.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_up_vld[k];
                end
            end
        end
    end

    // Tensor-end flag rides alongside the datapath
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_ld[k]) begin
                r_last[k] <= (k == 0) ? i_in.last_in : r_last[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Both branches share the same stage strobes
    qra_rescale u_main (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_acc   (i_in.main_acc),
        .i_mult  (w_cfg.main_mult),
        .i_shift (w_cfg.main_shift),
        .o_res   (w_main)
    );

    qra_rescale u_sc (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_acc   (i_in.shortcut_acc),
        .i_mult  (w_cfg.sc_mult),
        .i_shift (w_cfg.sc_shift),
        .o_res   (w_sc)
    );

    // Exact 33-bit sum, then ReLU and saturate to uint8
    assign w_sum = {w_main[ACC_W-1], w_main} + {w_sc[ACC_W-1], w_sc};

    always_comb begin
        if (w_sum[ACC_W]) begin
            w_clamp = '0;
        end else if (w_sum[ACC_W-1:OUT_W] != '0) begin
            w_clamp = OUT_MAX;
        end else begin
            w_clamp = w_sum[OUT_W-1:0];
        end
    end

    // Output register: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_ld[NSTG-1]) begin
            r_value <= w_clamp;
        end
    end

    assign o_out.valid     = r_vld[NSTG-1];
    assign o_out.out_value = r_value;
    assign o_out.last_out  = r_last[NSTG-1];

endmodule

@@ rtl/qra_cfg.sv @@
// ----------------------------------------------------------------------------
// qra_cfg
// APB register file holding the two multipliers and shifts.
// ----------------------------------------------------------------------------
module qra_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qra_pkg::ADDR_W-1:0]  paddr,
    input  logic [qra_pkg::DATA_W-1:0]  pwdata,
    output logic [qra_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output qra_pkg::t_cfg               o_cfg
);
    import qra_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_MAIN_MULT:  n_cfg.main_mult  = pwdata[MULT_W-1:0];
                REG_MAIN_SHIFT: n_cfg.main_shift = $signed(pwdata[SHIFT_W-1:0]);
                REG_SC_MULT:    n_cfg.sc_mult    = pwdata[MULT_W-1:0];
                REG_SC_SHIFT:   n_cfg.sc_shift   = $signed(pwdata[SHIFT_W-1:0]);
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.main_mult  <= MAIN_MULT_RST;
            r_cfg.main_shift <= MAIN_SHIFT_RST;
            r_cfg.sc_mult    <= SC_MULT_RST;
            r_cfg.sc_shift   <= SC_SHIFT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAIN_MULT:  prdata = {1'b0, r_cfg.main_mult};
            REG_MAIN_SHIFT: prdata = {{(DATA_W-SHIFT_W){r_cfg.main_shift[SHIFT_W-1]}},
                                      r_cfg.main_shift};
            REG_SC_MULT:    prdata = {1'b0, r_cfg.sc_mult};
            REG_SC_SHIFT:   prdata = {{(DATA_W-SHIFT_W){r_cfg.sc_shift[SHIFT_W-1]}},
                                      r_cfg.sc_shift};
            default:        prdata = '0;
        endcase
    end

endmodule

@@ rtl/qra_rescale.sv @@
// ----------------------------------------------------------------------------
// qra_rescale
// Four-stage requantizer: multiply, left shift, round, arithmetic right shift.
// ----------------------------------------------------------------------------
module qra_rescale (
    input  logic                                i_clk,
    input  qra_pkg::t_stage_en                  i_en,
    input  logic signed [qra_pkg::ACC_W-1:0]    i_acc,
    input  logic [qra_pkg::MULT_W-1:0]          i_mult,
    input  logic signed [qra_pkg::SHIFT_W-1:0]  i_shift,
    output logic signed [qra_pkg::ACC_W-1:0]    o_res
);
    import qra_pkg::*;

    logic [4:0]                w_lsh;
    logic [SHIFT_W:0]          w_neg;
    logic [SHIFT_W:0]          w_rsh_x;
    logic [SHIFT_W-1:0]        w_rsh;
    logic [SHIFT_W-1:0]        w_rnd_pos;
    logic signed [WIDE_W-1:0]  w_prod;
    logic [WIDE_W-1:0]         w_rnd;
    logic signed [WIDE_W-1:0]  w_asr;

    logic signed [PROD_W-1:0]  r_p;
    logic [WIDE_W-1:0]         r_v;
    logic signed [WIDE_W-1:0]  r_s;
    logic signed [ACC_W-1:0]   r_res;

    // Left amount for positive shift, extra right amount for negative shift
    assign w_lsh     = i_shift[SHIFT_W-1] ? 5'd0 : i_shift[4:0];
    assign w_neg     = i_shift[SHIFT_W-1] ? ((SHIFT_W+1)'(0) - {i_shift[SHIFT_W-1], i_shift})
                                          : '0;
    assign w_rsh_x   = (SHIFT_W+1)'(31) + w_neg;
    assign w_rsh     = w_rsh_x[SHIFT_W-1:0];
    assign w_rnd_pos = w_rsh - SHIFT_W'(1);
    assign w_rnd     = WIDE_W'(1) << w_rnd_pos;

    assign w_prod = $signed(i_acc) * $signed({1'b0, i_mult});
    assign w_asr  = r_s >>> w_rsh;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p <= w_prod[PROD_W-1:0];
        end
        if (i_en.lsh) begin
            r_v <= {r_p[PROD_W-1], r_p} << w_lsh;
        end
        if (i_en.rnd) begin
            r_s <= $signed(r_v + w_rnd);
        end
        if (i_en.rsh) begin
            r_res <= w_asr[ACC_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/qra_checker.sv @@
// ----------------------------------------------------------------------------
// qra_checker
// Port-level checks of the residual add block, bound to the top level.
// ----------------------------------------------------------------------------
module qra_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [qra_pkg::OUT_W-1:0]   i_out_value,
    input  logic                        i_last_out,
    input  logic                        i_pready
);
    import qra_pkg::*;

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // An empty output stage means every stage can take a beat
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output stage");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_last_out))
        else $error("output beat changed while stalled");

endmodule

bind quantized_residual_add_relu qra_checker u_qra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.out_value),
    .i_last_out  (o_out.last_out),
    .i_pready    (pready)
);
